/* rtl/core/psb_pkg.sv */
// ----------------------------------------------------------------------------
// psb_pkg
// Shared widths, types and helpers for the projected screen bounds unit.
// ----------------------------------------------------------------------------
package psb_pkg;

    localparam int COORD_W   = 32;
    localparam int COEF_W    = 32;
    localparam int CFG_W     = 64;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    // row sums need at most 41 bits, one spare for safety
    localparam int ACC_W     = 42;
    // numerator is the row sum scaled by 2^16
    localparam int NUM_W     = ACC_W + 16;
    localparam int DIV_CNT_W = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_W_FIRST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_W_SECOND = 3'd5;

    localparam logic [CFG_W-1:0] RST_ROW_X_FIRST  = 64'd72057594037927936;
    localparam logic [CFG_W-1:0] RST_ROW_X_SECOND = 64'd0;
    localparam logic [CFG_W-1:0] RST_ROW_Y_FIRST  = 64'd16777216;
    localparam logic [CFG_W-1:0] RST_ROW_Y_SECOND = 64'd0;
    localparam logic [CFG_W-1:0] RST_ROW_W_FIRST  = 64'd0;
    localparam logic [CFG_W-1:0] RST_ROW_W_SECOND = 64'd16777216;

    localparam logic signed [COORD_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] NEG_MIN = 32'sh8000_0000;

    // twelve coefficients, row r column c at r*4+c
    typedef logic [11:0][COEF_W-1:0] coef_set_t;

    // transformed vertex handed from front to back
    typedef struct packed {
        logic signed [ACC_W-1:0] tx;
        logic signed [ACC_W-1:0] ty;
        logic signed [ACC_W-1:0] tw;
        logic                    last;
    } xform_t;

    typedef enum logic [1:0] {F_IDLE, F_CALC, F_PUSH} front_state_t;
    typedef enum logic [1:0] {B_IDLE, B_DIV, B_FOLD} back_state_t;

    // multiply step to {row, column}
    function automatic logic [3:0] step_sel(input logic [3:0] step);
        logic [3:0] sel;
        unique case (step)
            4'd0:    sel = {2'd0, 2'd0};
            4'd1:    sel = {2'd0, 2'd1};
            4'd2:    sel = {2'd0, 2'd2};
            4'd3:    sel = {2'd1, 2'd0};
            4'd4:    sel = {2'd1, 2'd1};
            4'd5:    sel = {2'd1, 2'd2};
            4'd6:    sel = {2'd2, 2'd0};
            4'd7:    sel = {2'd2, 2'd1};
            4'd8:    sel = {2'd2, 2'd2};
            default: sel = {2'd0, 2'd0};
        endcase
        return sel;
    endfunction

endpackage

/* rtl/core/projected_screen_bounds_unit.sv */
// The transform front forms the row sums with one shared multiplier; the back
// divides by w in 58 one-bit divider steps when w is nonzero and skips the
// divide for zero w. The bit-serial divider limits the vertex rate; the front
// takes a new vertex once the last is queued, so it runs ahead of the back.
// Reset: aresetn synchronous active low; matrix returns to identity rows,
// running bounds to their empty values, queue and result valid flag cleared.
// ----------------------------------------------------------------------------
// projected_screen_bounds_unit
// Vertex transform, divide by w and bounding box of the projected points.
// ----------------------------------------------------------------------------
module projected_screen_bounds_unit #(
    parameter int QUEUE_DEPTH = psb_pkg::QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic                                cfg_wr_en,
    input  logic [psb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psb_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [psb_pkg::COORD_W-1:0]  s_vertex_x,
    input  logic signed [psb_pkg::COORD_W-1:0]  s_vertex_y,
    input  logic signed [psb_pkg::COORD_W-1:0]  s_vertex_z,
    input  logic                                s_last_vertex,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [psb_pkg::COORD_W-1:0]  m_least_x,
    output logic signed [psb_pkg::COORD_W-1:0]  m_greatest_x,
    output logic signed [psb_pkg::COORD_W-1:0]  m_least_y,
    output logic signed [psb_pkg::COORD_W-1:0]  m_greatest_y,
    output logic                                m_zero_w_seen
);

    logic [psb_pkg::CFG_W-1:0] cfg_reg [0:psb_pkg::NUM_REGS-1];
    psb_pkg::coef_set_t coef;
    psb_pkg::xform_t    push_data, pop_data;
    logic push, pop, full, empty;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[0] <= psb_pkg::RST_ROW_X_FIRST;
            cfg_reg[1] <= psb_pkg::RST_ROW_X_SECOND;
            cfg_reg[2] <= psb_pkg::RST_ROW_Y_FIRST;
            cfg_reg[3] <= psb_pkg::RST_ROW_Y_SECOND;
            cfg_reg[4] <= psb_pkg::RST_ROW_W_FIRST;
            cfg_reg[5] <= psb_pkg::RST_ROW_W_SECOND;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                psb_pkg::REG_ROW_X_FIRST:  cfg_reg[0] <= cfg_wr_data;
                psb_pkg::REG_ROW_X_SECOND: cfg_reg[1] <= cfg_wr_data;
                psb_pkg::REG_ROW_Y_FIRST:  cfg_reg[2] <= cfg_wr_data;
                psb_pkg::REG_ROW_Y_SECOND: cfg_reg[3] <= cfg_wr_data;
                psb_pkg::REG_ROW_W_FIRST:  cfg_reg[4] <= cfg_wr_data;
                psb_pkg::REG_ROW_W_SECOND: cfg_reg[5] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // coefficient layout, row r column c at r*4+c
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            coef[r*4+0] = cfg_reg[r*2][63:32];
            coef[r*4+1] = cfg_reg[r*2][31:0];
            coef[r*4+2] = cfg_reg[r*2+1][63:32];
            coef[r*4+3] = cfg_reg[r*2+1][31:0];
        end
    end

    psb_front u_front (
        .aclk, .aresetn, .coef,
        .s_valid, .s_ready, .s_vertex_x, .s_vertex_y, .s_vertex_z, .s_last_vertex,
        .q_push(push), .q_data(push_data), .q_full(full)
    );

    psb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn, .push, .push_data, .full, .pop, .pop_data, .empty
    );

    psb_back u_back (
        .aclk, .aresetn, .q_data(pop_data), .q_empty(empty), .q_pop(pop),
        .m_valid, .m_ready, .m_least_x, .m_greatest_x, .m_least_y, .m_greatest_y,
        .m_zero_w_seen
    );

endmodule

/* rtl/core/psb_front.sv */
// ----------------------------------------------------------------------------
// psb_front
// Accepts vertices and forms the three row sums with one shared multiplier.
// ----------------------------------------------------------------------------
module psb_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  psb_pkg::coef_set_t             coef,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [psb_pkg::COORD_W-1:0] s_vertex_x,
    input  logic signed [psb_pkg::COORD_W-1:0] s_vertex_y,
    input  logic signed [psb_pkg::COORD_W-1:0] s_vertex_z,
    input  logic                           s_last_vertex,
    output logic                           q_push,
    output psb_pkg::xform_t                q_data,
    input  logic                           q_full
);

    localparam int AW = psb_pkg::ACC_W;

    psb_pkg::front_state_t state_reg, state_next;
    logic [3:0]  step_reg;
    logic [1:0]  prow_reg;
    logic        pend_reg;
    logic signed [63:0] prod_reg;
    logic signed [psb_pkg::COORD_W-1:0] crd_reg [0:2];
    logic signed [AW-1:0] acc_reg [0:2];
    logic        last_reg;

    logic [3:0]  sel;
    logic signed [psb_pkg::COEF_W-1:0] mul_a;
    logic signed [psb_pkg::COORD_W-1:0] mul_b;
    logic        accept;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            psb_pkg::F_IDLE: if (s_valid) state_next = psb_pkg::F_CALC;
            psb_pkg::F_CALC: if (step_reg == 4'd9) state_next = psb_pkg::F_PUSH;
            psb_pkg::F_PUSH: if (!q_full) state_next = psb_pkg::F_IDLE;
            default: state_next = psb_pkg::F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = (state_reg == psb_pkg::F_IDLE);
        q_push  = (state_reg == psb_pkg::F_PUSH) && !q_full;
        q_data.tx   = acc_reg[0];
        q_data.ty   = acc_reg[1];
        q_data.tw   = acc_reg[2];
        q_data.last = last_reg;
    end

    assign accept = s_valid && s_ready;
    assign sel    = psb_pkg::step_sel(step_reg);
    assign mul_a  = coef[{sel[3:2], 2'b00} + {2'b00, sel[1:0]}];
    assign mul_b  = crd_reg[sel[1:0]];

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= psb_pkg::F_IDLE;
            pend_reg  <= 1'b0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                step_reg <= '0;
                pend_reg <= 1'b0;
            end else if (state_reg == psb_pkg::F_CALC) begin
                step_reg <= step_reg + 4'd1;
                pend_reg <= (step_reg < 4'd9);
            end
        end
    end

    // multiply and accumulate datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            crd_reg[0] <= s_vertex_x;
            crd_reg[1] <= s_vertex_y;
            crd_reg[2] <= s_vertex_z;
            last_reg   <= s_last_vertex;
            // constant column times 1.0 is the coefficient floored by 2^8
            acc_reg[0] <= AW'(signed'(coef[3][31:8]));
            acc_reg[1] <= AW'(signed'(coef[7][31:8]));
            acc_reg[2] <= AW'(signed'(coef[11][31:8]));
        end else if (state_reg == psb_pkg::F_CALC) begin
            if (step_reg < 4'd9) begin
                prod_reg <= 64'(mul_a) * 64'(mul_b);
                prow_reg <= sel[3:2];
            end
            if (pend_reg) begin
                acc_reg[prow_reg] <= acc_reg[prow_reg]
                                     + AW'(signed'(prod_reg[63:24]));
            end
        end
    end

endmodule

/* rtl/core/psb_queue.sv */
// ----------------------------------------------------------------------------
// psb_queue
// Small first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module psb_queue #(
    parameter int DEPTH = psb_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  psb_pkg::xform_t push_data,
    output logic            full,
    input  logic            pop,
    output psb_pkg::xform_t pop_data,
    output logic            empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    psb_pkg::xform_t mem [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push || pop) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

/* rtl/core/psb_back.sv */
// ----------------------------------------------------------------------------
// psb_back
// Divides the x and y row sums by w, saturates and folds them into running bounds.
// ----------------------------------------------------------------------------
module psb_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  psb_pkg::xform_t q_data,
    input  logic            q_empty,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic signed [psb_pkg::COORD_W-1:0] m_least_x,
    output logic signed [psb_pkg::COORD_W-1:0] m_greatest_x,
    output logic signed [psb_pkg::COORD_W-1:0] m_least_y,
    output logic signed [psb_pkg::COORD_W-1:0] m_greatest_y,
    output logic            m_zero_w_seen
);

    localparam int AW = psb_pkg::ACC_W;
    localparam int NW = psb_pkg::NUM_W;
    localparam int CNTW = psb_pkg::DIV_CNT_W;

    psb_pkg::back_state_t state_reg, state_next;
    logic [CNTW-1:0] cnt_reg;
    logic [NW-1:0]   qx_reg, qy_reg;
    logic [AW-1:0]   rx_reg, ry_reg, dmag_reg;
    logic            negx_reg, negy_reg, zero_reg, last_reg;
    logic signed [psb_pkg::COORD_W-1:0] lx_reg, gx_reg, ly_reg, gy_reg;
    logic            sticky_reg, m_valid_reg;
    logic signed [psb_pkg::COORD_W-1:0] ox_lx_reg, ox_gx_reg, ox_ly_reg, ox_gy_reg;
    logic            ozw_reg;

    logic signed [NW-1:0] nx, ny;
    logic [AW:0]     tx_trial, ty_trial;
    logic signed [psb_pkg::COORD_W-1:0] px, py, nlx, ngx, nly, ngy;
    logic            fold_go, nsticky;

    // saturate a magnitude quotient with its sign
    function automatic logic signed [31:0] sat_q(input logic [NW-1:0] q, input logic neg);
        logic signed [31:0] r;
        if (neg) r = (q > NW'(33'h1_0000_0000 >> 1)) ? psb_pkg::NEG_MIN : -signed'(q[31:0]);
        else     r = (q > NW'(32'h7FFF_FFFF)) ? psb_pkg::POS_MAX : signed'(q[31:0]);
        return r;
    endfunction

    assign fold_go = (state_reg == psb_pkg::B_FOLD) && (!last_reg || !m_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            psb_pkg::B_IDLE: if (!q_empty)
                        state_next = (q_data.tw == '0) ? psb_pkg::B_FOLD : psb_pkg::B_DIV;
            psb_pkg::B_DIV:  if (cnt_reg == CNTW'(1)) state_next = psb_pkg::B_FOLD;
            psb_pkg::B_FOLD: if (fold_go) state_next = psb_pkg::B_IDLE;
            default: state_next = psb_pkg::B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        q_pop         = (state_reg == psb_pkg::B_IDLE) && !q_empty;
        m_valid       = m_valid_reg;
        m_least_x     = ox_lx_reg;
        m_greatest_x  = ox_gx_reg;
        m_least_y     = ox_ly_reg;
        m_greatest_y  = ox_gy_reg;
        m_zero_w_seen = ozw_reg;
    end

    // numerators and division trial subtracts
    assign nx = {q_data.tx, 16'd0};
    assign ny = {q_data.ty, 16'd0};
    assign tx_trial = {rx_reg, qx_reg[NW-1]} - {1'b0, dmag_reg};
    assign ty_trial = {ry_reg, qy_reg[NW-1]} - {1'b0, dmag_reg};

    // projected values and folded bounds
    always_comb begin
        px = sat_q(qx_reg, negx_reg);
        py = sat_q(qy_reg, negy_reg);
        nlx = lx_reg; ngx = gx_reg; nly = ly_reg; ngy = gy_reg;
        nsticky = sticky_reg | zero_reg;
        if (!zero_reg) begin
            if (px < lx_reg) nlx = px;
            if (px > gx_reg) ngx = px;
            if (py < ly_reg) nly = py;
            if (py > gy_reg) ngy = py;
        end
    end

    // control state and running bounds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= psb_pkg::B_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            lx_reg <= psb_pkg::POS_MAX; gx_reg <= psb_pkg::NEG_MIN;
            ly_reg <= psb_pkg::POS_MAX; gy_reg <= psb_pkg::NEG_MIN;
            sticky_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop) cnt_reg <= CNTW'(NW);
            else if (state_reg == psb_pkg::B_DIV) cnt_reg <= cnt_reg - 1'b1;
            // result valid set on the last fold, cleared once taken
            if (fold_go && last_reg) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (fold_go) begin
                if (last_reg) begin
                    lx_reg <= psb_pkg::POS_MAX; gx_reg <= psb_pkg::NEG_MIN;
                    ly_reg <= psb_pkg::POS_MAX; gy_reg <= psb_pkg::NEG_MIN;
                    sticky_reg <= 1'b0;
                end else begin
                    lx_reg <= nlx; gx_reg <= ngx; ly_reg <= nly; gy_reg <= ngy;
                    sticky_reg <= nsticky;
                end
            end
        end
    end

    // divider and result register
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            negx_reg <= nx[NW-1] ^ q_data.tw[AW-1];
            negy_reg <= ny[NW-1] ^ q_data.tw[AW-1];
            qx_reg   <= nx[NW-1] ? NW'(-nx) : NW'(nx);
            qy_reg   <= ny[NW-1] ? NW'(-ny) : NW'(ny);
            dmag_reg <= q_data.tw[AW-1] ? AW'(-q_data.tw) : AW'(q_data.tw);
            rx_reg   <= '0;
            ry_reg   <= '0;
            zero_reg <= (q_data.tw == '0);
            last_reg <= q_data.last;
        end else if (state_reg == psb_pkg::B_DIV) begin
            // restoring step, quotient bits shift in behind the numerator
            if (!tx_trial[AW]) rx_reg <= tx_trial[AW-1:0];
            else               rx_reg <= {rx_reg[AW-2:0], qx_reg[NW-1]};
            qx_reg <= {qx_reg[NW-2:0], ~tx_trial[AW]};
            if (!ty_trial[AW]) ry_reg <= ty_trial[AW-1:0];
            else               ry_reg <= {ry_reg[AW-2:0], qy_reg[NW-1]};
            qy_reg <= {qy_reg[NW-2:0], ~ty_trial[AW]};
        end
        if (fold_go && last_reg) begin
            ox_lx_reg <= nlx; ox_gx_reg <= ngx;
            ox_ly_reg <= nly; ox_gy_reg <= ngy;
            ozw_reg   <= nsticky;
        end
    end

endmodule
